/* hdl/markov_transition_sampler_defines.svh */
// ----------------------------------------------------------------------------
// Markov transition sampler assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MARKOV_TRANSITION_SAMPLER_DEFINES_SVH
`define MARKOV_TRANSITION_SAMPLER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("markov_transition_sampler: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MTS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("markov_transition_sampler: next-cycle check failed");

`endif

/* hdl/mts_pkg.sv */
// ----------------------------------------------------------------------------
// Markov transition sampler package
// Sizes, operation and status codes and the shared structures.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int MAX_STATES = 16;
  localparam int IDX_W      = $clog2(MAX_STATES);
  localparam int USED_W     = IDX_W + 1;
  localparam int CLR_W      = IDX_W + 2;
  localparam int TADDR_W    = 2 * IDX_W;
  localparam int SYM_W      = 16;
  localparam int CNT_W      = 16;
  localparam int SUM_W      = CNT_W + IDX_W;
  localparam int RND_W      = 16;
  localparam int PROD_W     = RND_W + SUM_W;
  localparam int MODE_W     = 2;
  localparam int STAT_W     = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [MODE_W-1:0] MODE_TRAIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SET   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_GEN   = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 3'd1;
  localparam logic [STAT_W-1:0] ST_UNK   = 3'd2;
  localparam logic [STAT_W-1:0] ST_DUP   = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SYM_W-1:0]  symbol;
    logic [SYM_W-1:0]  target_symbol;
    logic [CNT_W-1:0]  weight;
    logic              first;
    logic [RND_W-1:0]  random_value;
  } mts_item_t;

  typedef struct packed {
    logic [SYM_W-1:0]  out_symbol;
    logic [IDX_W-1:0]  out_index;
    logic [STAT_W-1:0] status;
  } mts_result_t;

  typedef struct packed {
    logic start;
    logic take;
  } mts_req_t;

  typedef struct packed {
    logic idle;
    logic done;
  } mts_stat_t;

endpackage

/* hdl/mts_if.sv */
// ----------------------------------------------------------------------------
// Markov transition sampler channel interfaces
// Valid/ready channels for input transactions and result transactions.
// ----------------------------------------------------------------------------
interface mts_in_if
  import mts_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [SYM_W-1:0]  symbol;
  logic [SYM_W-1:0]  target_symbol;
  logic [CNT_W-1:0]  weight;
  logic              first;
  logic [RND_W-1:0]  random_value;

  modport source (output valid, mode, symbol, target_symbol, weight, first, random_value,
                  input ready);
  modport sink (input valid, mode, symbol, target_symbol, weight, first, random_value,
                output ready);
endinterface

interface mts_out_if
  import mts_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [SYM_W-1:0]  out_symbol;
  logic [IDX_W-1:0]  out_index;
  logic [STAT_W-1:0] status;

  modport source (output valid, out_symbol, out_index, status, input ready);
  modport sink (input valid, out_symbol, out_index, status, output ready);
endinterface

/* hdl/mts_ram.sv */
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module mts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

/* hdl/mts_core.sv */
// ----------------------------------------------------------------------------
// Markov transition sampler core
// Sequencer around the name, start weight and transition count memories.
// ----------------------------------------------------------------------------
module mts_core
  import mts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  mts_req_t    req,
  input  mts_item_t   item,
  output mts_stat_t   stat,
  output mts_result_t res
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SRCH  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_INS   = 4'd3;
  localparam logic [3:0] S_CLR   = 4'd4;
  localparam logic [3:0] S_TRAIN = 4'd5;
  localparam logic [3:0] S_RMW   = 4'd6;
  localparam logic [3:0] S_GMUL  = 4'd7;
  localparam logic [3:0] S_GEN   = 4'd8;
  localparam logic [3:0] S_GNAME = 4'd9;
  localparam logic [3:0] S_GOUT  = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  localparam logic [1:0] K_SW  = 2'd0;
  localparam logic [1:0] K_INC = 2'd1;
  localparam logic [1:0] K_SET = 2'd2;

  localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(2 * MAX_STATES - 1);

  logic [3:0]        state_r, state_nxt;
  mts_item_t         item_r, item_nxt;
  mts_result_t       res_r, res_nxt;
  logic [CLR_W-1:0]  cnt_r, cnt_nxt;
  logic              rdv_r, rdv_nxt;
  logic [IDX_W-1:0]  rdi_r, rdi_nxt;
  logic              fa_r, fa_nxt, fb_r, fb_nxt;
  logic [IDX_W-1:0]  ia_r, ia_nxt, ib_r, ib_nxt;
  logic [USED_W-1:0] used_r, used_nxt;
  logic [IDX_W-1:0]  prev_r, prev_nxt;
  logic              prevv_r, prevv_nxt;
  logic [SUM_W-1:0]  ssum_r, ssum_nxt;
  logic [SUM_W-1:0]  cum_r, cum_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic              usest_r, usest_nxt;
  logic              hit_r, hit_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic [TADDR_W-1:0] taddr_r, taddr_nxt;
  logic [SUM_W-1:0]  rsum_r [MAX_STATES];

  // Memory ports
  logic               nm_we;
  logic [IDX_W-1:0]   nm_waddr, nm_raddr;
  logic [SYM_W-1:0]   nm_rdata;
  logic               sw_we;
  logic [IDX_W-1:0]   sw_waddr, sw_raddr;
  logic [CNT_W-1:0]   sw_wdata, sw_rdata;
  logic               tr_we;
  logic [TADDR_W-1:0] tr_waddr, tr_raddr;
  logic [CNT_W-1:0]   tr_wdata, tr_rdata;

  // Row sum register file: one read index, one write index
  logic               rs_we;
  logic [IDX_W-1:0]   rs_ridx, rs_widx;
  logic [SUM_W-1:0]   rs_wdata, rs_rd;

  logic               cnt_lt_used, full, prev_out;
  logic [CNT_W-1:0]   gdata, ins_w;
  logic [SUM_W-1:0]   cum_add;
  logic [PROD_W-1:0]  cum_scaled;

  mts_ram #(.WIDTH(SYM_W), .DEPTH(MAX_STATES)) u_names (
    .clk, .we(nm_we), .waddr(nm_waddr), .wdata(item_r.symbol),
    .raddr(nm_raddr), .rdata(nm_rdata));

  mts_ram #(.WIDTH(CNT_W), .DEPTH(MAX_STATES)) u_start (
    .clk, .we(sw_we), .waddr(sw_waddr), .wdata(sw_wdata),
    .raddr(sw_raddr), .rdata(sw_rdata));

  mts_ram #(.WIDTH(CNT_W), .DEPTH(MAX_STATES * MAX_STATES)) u_trans (
    .clk, .we(tr_we), .waddr(tr_waddr), .wdata(tr_wdata),
    .raddr(tr_raddr), .rdata(tr_rdata));

  always_ff @(posedge clk) begin
    if (rs_we) begin
      rsum_r[rs_widx] <= rs_wdata;
    end
  end
  assign rs_rd = rsum_r[rs_ridx];

  assign cnt_lt_used = cnt_r < CLR_W'(used_r);
  assign full        = used_r == USED_W'(MAX_STATES);
  assign prev_out    = {1'b0, prev_r} >= used_r;
  assign gdata       = usest_r ? sw_rdata : tr_rdata;
  assign cum_add     = cum_r + SUM_W'(gdata);
  // cum * 65535 as a shift and a subtract
  assign cum_scaled  = (PROD_W'(cum_add) << RND_W) - PROD_W'(cum_add);
  assign ins_w       = (item_r.mode == MODE_TRAIN) ? '0 : item_r.weight;

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    res_nxt   = res_r;
    cnt_nxt   = cnt_r;
    rdv_nxt   = 1'b0;
    rdi_nxt   = rdi_r;
    fa_nxt    = fa_r;
    fb_nxt    = fb_r;
    ia_nxt    = ia_r;
    ib_nxt    = ib_r;
    used_nxt  = used_r;
    prev_nxt  = prev_r;
    prevv_nxt = prevv_r;
    ssum_nxt  = ssum_r;
    cum_nxt   = cum_r;
    prod_nxt  = prod_r;
    usest_nxt = usest_r;
    hit_nxt   = hit_r;
    k_nxt     = k_r;
    kind_nxt  = kind_r;
    taddr_nxt = taddr_r;

    nm_we    = 1'b0;
    nm_waddr = used_r[IDX_W-1:0];
    nm_raddr = cnt_r[IDX_W-1:0];
    sw_we    = 1'b0;
    sw_waddr = ia_r;
    sw_wdata = sw_rdata + CNT_W'(1);
    sw_raddr = cnt_r[IDX_W-1:0];
    tr_we    = 1'b0;
    tr_waddr = taddr_r;
    tr_wdata = tr_rdata + CNT_W'(1);
    tr_raddr = {prev_r, cnt_r[IDX_W-1:0]};
    rs_we    = 1'b0;
    rs_widx  = ia_r;
    rs_ridx  = prev_r;
    rs_wdata = rs_rd + SUM_W'(1);

    unique case (state_r)
      S_IDLE: begin
        if (req.start) begin
          item_nxt  = item;
          cnt_nxt   = '0;
          fa_nxt    = 1'b0;
          fb_nxt    = 1'b0;
          state_nxt = S_SRCH;
        end
      end

      // Sweep the name table once, matching source and target together.
      S_SRCH: begin
        if (cnt_lt_used) begin
          rdv_nxt = 1'b1;
          rdi_nxt = cnt_r[IDX_W-1:0];
          cnt_nxt = cnt_r + CLR_W'(1);
        end
        if (rdv_r) begin
          if (!fa_r && nm_rdata == item_r.symbol) begin
            fa_nxt = 1'b1;
            ia_nxt = rdi_r;
          end
          if (!fb_r && nm_rdata == item_r.target_symbol) begin
            fb_nxt = 1'b1;
            ib_nxt = rdi_r;
          end
        end
        if (!cnt_lt_used && !rdv_r) begin
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        res_nxt = '{out_symbol: item_r.symbol, out_index: '0, status: ST_OK};
        unique case (item_r.mode)
          MODE_TRAIN: begin
            if (fa_r) begin
              state_nxt = S_TRAIN;
            end else if (full) begin
              res_nxt.status = ST_FULL;
              prevv_nxt      = 1'b0;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_INS;
            end
          end
          MODE_ADD: begin
            if (fa_r) begin
              res_nxt.status    = ST_DUP;
              res_nxt.out_index = ia_r;
              state_nxt         = S_DONE;
            end else if (full) begin
              res_nxt.status = ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_INS;
            end
          end
          MODE_SET: begin
            if (fa_r && fb_r) begin
              tr_raddr  = {ia_r, ib_r};
              taddr_nxt = {ia_r, ib_r};
              kind_nxt  = K_SET;
              state_nxt = S_RMW;
            end else begin
              res_nxt.status = ST_UNK;
              state_nxt      = S_DONE;
            end
          end
          MODE_GEN: begin
            if (used_r == '0) begin
              res_nxt   = '{out_symbol: '0, out_index: '0, status: ST_EMPTY};
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_GMUL;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end

      // New state: name, start weight and row sum, then clear row and column.
      S_INS: begin
        nm_we    = 1'b1;
        sw_we    = 1'b1;
        sw_waddr = used_r[IDX_W-1:0];
        sw_wdata = ins_w;
        ssum_nxt = ssum_r + SUM_W'(ins_w);
        rs_we    = 1'b1;
        rs_widx  = used_r[IDX_W-1:0];
        rs_wdata = '0;
        ia_nxt   = used_r[IDX_W-1:0];
        used_nxt = used_r + USED_W'(1);
        cnt_nxt  = '0;
        state_nxt = S_CLR;
      end

      S_CLR: begin
        tr_we    = 1'b1;
        tr_wdata = '0;
        tr_waddr = cnt_r[0] ? {cnt_r[IDX_W:1], ia_r} : {ia_r, cnt_r[IDX_W:1]};
        cnt_nxt  = cnt_r + CLR_W'(1);
        if (cnt_r == CLR_LAST) begin
          if (item_r.mode == MODE_TRAIN) begin
            state_nxt = S_TRAIN;
          end else begin
            res_nxt   = '{out_symbol: item_r.symbol, out_index: ia_r, status: ST_OK};
            state_nxt = S_DONE;
          end
        end
      end

      S_TRAIN: begin
        sw_raddr = ia_r;
        tr_raddr = {prev_r, ia_r};
        taddr_nxt = {prev_r, ia_r};
        if (item_r.first || !prevv_r || prev_out) begin
          kind_nxt = K_SW;
        end else begin
          kind_nxt = K_INC;
        end
        state_nxt = S_RMW;
      end

      S_RMW: begin
        res_nxt   = '{out_symbol: item_r.symbol, out_index: ia_r, status: ST_OK};
        state_nxt = S_DONE;
        unique case (kind_r)
          K_SW: begin
            if (sw_rdata != CNT_MAX) begin
              sw_we    = 1'b1;
              ssum_nxt = ssum_r + SUM_W'(1);
            end
            prev_nxt  = ia_r;
            prevv_nxt = 1'b1;
          end
          K_INC: begin
            if (tr_rdata != CNT_MAX) begin
              tr_we   = 1'b1;
              rs_we   = 1'b1;
              rs_widx = prev_r;
            end
            prev_nxt  = ia_r;
            prevv_nxt = 1'b1;
          end
          K_SET: begin
            tr_we    = 1'b1;
            tr_wdata = item_r.weight;
            rs_ridx  = ia_r;
            rs_we    = 1'b1;
            rs_wdata = rs_rd - SUM_W'(tr_rdata) + SUM_W'(item_r.weight);
          end
          default: ;
        endcase
      end

      // Pick the weight set and scale the draw by its sum.
      S_GMUL: begin
        if (item_r.first || !prevv_r || prev_out || rs_rd == '0) begin
          usest_nxt = 1'b1;
          prod_nxt  = PROD_W'(item_r.random_value) * PROD_W'(ssum_r);
        end else begin
          usest_nxt = 1'b0;
          prod_nxt  = PROD_W'(item_r.random_value) * PROD_W'(rs_rd);
        end
        cnt_nxt   = '0;
        cum_nxt   = '0;
        hit_nxt   = 1'b0;
        state_nxt = S_GEN;
      end

      // Cumulative walk: one weight read issued and one compared per cycle.
      S_GEN: begin
        if (!hit_r && cnt_lt_used) begin
          rdv_nxt = 1'b1;
          rdi_nxt = cnt_r[IDX_W-1:0];
          cnt_nxt = cnt_r + CLR_W'(1);
        end
        if (rdv_r && !hit_r) begin
          cum_nxt = cum_add;
          if (cum_scaled >= prod_r) begin
            hit_nxt = 1'b1;
            k_nxt   = rdi_r;
          end
        end
        if (hit_r) begin
          state_nxt = S_GNAME;
        end else if (!cnt_lt_used && !rdv_r) begin
          k_nxt     = IDX_W'(used_r - USED_W'(1));
          state_nxt = S_GNAME;
        end
      end

      S_GNAME: begin
        nm_raddr  = k_r;
        prev_nxt  = k_r;
        prevv_nxt = 1'b1;
        state_nxt = S_GOUT;
      end

      S_GOUT: begin
        res_nxt   = '{out_symbol: nm_rdata, out_index: k_r, status: ST_OK};
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (req.take) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      prev_r  <= '0;
      prevv_r <= 1'b0;
      ssum_r  <= '0;
      rdv_r   <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      prev_r  <= prev_nxt;
      prevv_r <= prevv_nxt;
      ssum_r  <= ssum_nxt;
      rdv_r   <= rdv_nxt;
      hit_r   <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    res_r   <= res_nxt;
    cnt_r   <= cnt_nxt;
    rdi_r   <= rdi_nxt;
    fa_r    <= fa_nxt;
    fb_r    <= fb_nxt;
    ia_r    <= ia_nxt;
    ib_r    <= ib_nxt;
    cum_r   <= cum_nxt;
    prod_r  <= prod_nxt;
    usest_r <= usest_nxt;
    k_r     <= k_nxt;
    kind_r  <= kind_nxt;
    taddr_r <= taddr_nxt;
  end

  assign stat.idle = state_r == S_IDLE;
  assign stat.done = state_r == S_DONE;
  assign res       = res_r;
endmodule

/* hdl/markov_transition_sampler.sv */
// ----------------------------------------------------------------------------
// Markov transition sampler
// First-order Markov chain engine: training, state and transition set-up,
// and weighted sampling of the next symbol.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake      Payload
//   in_ch    sink       valid / ready  mode, symbol, target_symbol, weight,
//                                      first, random_value
//   out_ch   source     valid / ready  out_symbol, out_index, status
//
// One transaction is worked on at a time. Every operation first sweeps the
// name memory. Adding a new state then clears its row and column through the
// single write port of the transition memory. Training then does a
// read-modify-write of a start weight or a transition count; generation adds
// the cumulative walk and the name read. Reset is synchronous and active low;
// no clearing pass is needed, since a state's row and column are cleared when
// it is added. The result register lets the next input transaction be taken
// while a result waits on a stalled output.
//
module markov_transition_sampler
  import mts_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  mts_in_if.sink   in_ch,
  mts_out_if.source out_ch
);
  `include "markov_transition_sampler_defines.svh"

  mts_req_t    req;
  mts_stat_t   stat;
  mts_item_t   item;
  mts_result_t core_res;
  mts_result_t out_r;
  logic        out_v_r, out_v_nxt;

  // The core only takes a transaction while its sequencer is idle.
  assign in_ch.ready = stat.idle;
  assign req.start   = in_ch.valid && stat.idle;

  assign item = '{mode: in_ch.mode, symbol: in_ch.symbol,
                  target_symbol: in_ch.target_symbol, weight: in_ch.weight,
                  first: in_ch.first, random_value: in_ch.random_value};

  // A finished result moves into the output register once it is free.
  assign req.take  = stat.done && (!out_v_r || out_ch.ready);
  assign out_v_nxt = req.take || (out_v_r && !out_ch.ready);

  mts_core u_core (
    .clk,
    .rst_n,
    .req,
    .item,
    .stat,
    .res(core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.take) begin
      out_r <= core_res;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.out_symbol = out_r.out_symbol;
  assign out_ch.out_index  = out_r.out_index;
  assign out_ch.status     = out_r.status;

  // The sequencer must leave idle as soon as it takes a transaction.
  `MTS_ASSERT_NXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
  // Only defined status codes are ever reported.
  `MTS_ASSERT_IMP(a_status_range, out_ch.valid, out_ch.status <= ST_EMPTY)
  // An empty chain reports symbol and index zero.
  `MTS_ASSERT_IMP(a_empty_result, out_ch.valid && out_ch.status == ST_EMPTY, out_ch.out_symbol == '0 && out_ch.out_index == '0)
endmodule
